### rtl/i2cbl_pkg.sv
// Shared types and phase codes for the I2C bit-level master.
package i2cbl_pkg;

	localparam int unsigned DLY_W = 10;  // 4 us * 255 ticks fits in 10 bits

	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_S1   = 5'd1;
	localparam logic [4:0] PH_S2   = 5'd2;
	localparam logic [4:0] PH_S3   = 5'd3;
	localparam logic [4:0] PH_P1   = 5'd4;
	localparam logic [4:0] PH_P2   = 5'd5;
	localparam logic [4:0] PH_P3   = 5'd6;
	localparam logic [4:0] PH_W0   = 5'd7;
	localparam logic [4:0] PH_WB1  = 5'd8;
	localparam logic [4:0] PH_WB2  = 5'd9;
	localparam logic [4:0] PH_WB3  = 5'd10;
	localparam logic [4:0] PH_WT1  = 5'd11;
	localparam logic [4:0] PH_WT2  = 5'd12;
	localparam logic [4:0] PH_WT3  = 5'd13;
	localparam logic [4:0] PH_R0   = 5'd14;
	localparam logic [4:0] PH_RB1  = 5'd15;
	localparam logic [4:0] PH_RB2  = 5'd16;
	localparam logic [4:0] PH_RB3  = 5'd17;
	localparam logic [4:0] PH_RB4  = 5'd18;
	localparam logic [4:0] PH_RB5  = 5'd19;
	localparam logic [4:0] PH_RA1  = 5'd20;
	localparam logic [4:0] PH_RA2  = 5'd21;
	localparam logic [4:0] PH_RA3  = 5'd22;
	localparam logic [4:0] PH_A0   = 5'd23;
	localparam logic [4:0] PH_A1   = 5'd24;
	localparam logic [4:0] PH_A2   = 5'd25;
	localparam logic [4:0] PH_A3   = 5'd26;

	localparam logic [2:0] FN_START = 3'd0;
	localparam logic [2:0] FN_STOP  = 3'd1;
	localparam logic [2:0] FN_WRITE = 3'd2;
	localparam logic [2:0] FN_READ  = 3'd3;
	localparam logic [2:0] FN_WACK  = 3'd4;

	localparam logic REG_TPU   = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [7:0] TPU_RST   = 8'd8;
	localparam logic [7:0] LIMIT_RST = 8'd250;

	typedef struct packed {
		logic [4:0]       phase;
		logic [DLY_W-1:0] dly;
		logic [3:0]       bcnt;
		logic [7:0]       shreg;
		logic [7:0]       poll;
		logic             scl;
		logic             pull;
		logic [7:0]       rx;
		logic             ackf;
		logic             nackl;
	} st_t;

	// idle, pins released
	localparam st_t ST_RST = '{phase: PH_IDLE, dly: '0, bcnt: '0, shreg: '0, poll: '0,
		scl: 1'b1, pull: 1'b0, rx: '0, ackf: 1'b0, nackl: 1'b0};

	typedef struct packed {
		st_t  st;
		logic cont;
		logic done;
	} act_t;

endpackage

### rtl/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: input stage, sequencer state, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_stall  | cmd_valid func tx_byte nack_after_read sda_in
//  out     | out_valid / out_stall| scl_level sda_pull_low busy_res done_res rx_byte
//          |                      | ack_missing
//  cfg     | cfg_we               | cfg_index cfg_wdata (0 ticks/us, 1 ack poll limit)
//
// One tick transaction is taken per clock while in_stall is low. It is held in the input
// register, then loaded into the result register, which raises out_valid. The sequencer
// state advances in the same edge that loads the result register.
// arst_n clears the sequencer (pins released, idle) and restores register defaults.
// A stall on the output holds the result register and backs up into the input
// register; in_stall rises only while both are full and the output is stalled.
module i2c_bit_level_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd_valid,
	input  logic [2:0] func,
	input  logic [7:0] tx_byte,
	input  logic       nack_after_read,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_pull_low,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       ack_missing,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);
	import i2cbl_pkg::*;

	// configuration
	logic [7:0] tpu_q, limit_q;

	// input stage
	logic       vld_s1;
	logic       cmdv_s1, nack_s1, sda_s1;
	logic [2:0] func_s1;
	logic [7:0] tx_s1;

	// sequencer state and result register
	st_t  st_q, st_nxt;
	logic done_nxt;
	logic ovld_q;
	logic scl_q, pull_q, busy_q, done_q, ack_q;
	logic [7:0] rx_q;

	logic adv, in_acc;

	assign adv      = ~ovld_q | ~out_stall;
	assign in_stall = vld_s1 & ~adv;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q   <= TPU_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TPU:   tpu_q   <= cfg_wdata;
				REG_LIMIT: limit_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_acc | (vld_s1 & ~adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmdv_s1 <= cmd_valid;
			func_s1 <= func;
			tx_s1   <= tx_byte;
			nack_s1 <= nack_after_read;
			sda_s1  <= sda_in;
		end
	end

	i2cbl_core u_core (
		.cur             (st_q),
		.cmd_valid       (cmdv_s1),
		.func            (func_s1),
		.tx_byte         (tx_s1),
		.nack_after_read (nack_s1),
		.sda_in          (sda_s1),
		.tpu             (tpu_q),
		.limit           (limit_q),
		.nxt             (st_nxt),
		.done            (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_RST;
			ovld_q <= 1'b0;
		end else begin
			if (vld_s1 && adv) begin
				st_q <= st_nxt;
			end
			ovld_q <= (vld_s1 & adv) | (ovld_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && adv) begin
			scl_q  <= st_nxt.scl;
			pull_q <= st_nxt.pull;
			busy_q <= (st_nxt.phase != PH_IDLE);
			done_q <= done_nxt;
			rx_q   <= st_nxt.rx;
			ack_q  <= st_nxt.ackf;
		end
	end

	assign out_valid    = ovld_q;
	assign scl_level    = scl_q;
	assign sda_pull_low = pull_q;
	assign busy_res     = busy_q;
	assign done_res     = done_q;
	assign rx_byte      = rx_q;
	assign ack_missing  = ack_q;

endmodule

### rtl/i2cbl_core.sv
// Next-state logic: one tick of the pin sequencer.
module i2cbl_core (
	input  i2cbl_pkg::st_t cur,
	input  logic           cmd_valid,
	input  logic [2:0]     func,
	input  logic [7:0]     tx_byte,
	input  logic           nack_after_read,
	input  logic           sda_in,
	input  logic [7:0]     tpu,
	input  logic [7:0]     limit,
	output i2cbl_pkg::st_t nxt,
	output logic           done
);
	import i2cbl_pkg::*;

	logic [7:0]       t_eff;
	logic [DLY_W-1:0] d1, d2, d4;
	st_t              s0;
	logic             run;
	act_t             a1, a2;

	assign t_eff = (tpu == 8'd0) ? 8'd1 : tpu;
	assign d1 = {2'b00, t_eff};
	assign d2 = {1'b0, t_eff, 1'b0};
	assign d4 = {t_eff, 2'b00};

	// one phase action; cont set when the next phase acts in the same tick
	function automatic act_t act(input st_t s);
		act_t r;
		r      = '0;
		r.st   = s;
		case (s.phase)
			PH_S1: begin r.st.scl = 1'b1; r.st.pull = 1'b0; r.st.dly = d4; r.st.phase = PH_S2; end
			PH_S2: begin r.st.pull = 1'b1; r.st.dly = d4; r.st.phase = PH_S3; end
			PH_S3: begin r.st.scl = 1'b0; r.st.phase = PH_IDLE; r.st.dly = '0; r.done = 1'b1; end
			PH_P1: begin r.st.scl = 1'b0; r.st.pull = 1'b1; r.st.dly = d4; r.st.phase = PH_P2; end
			PH_P2: begin r.st.scl = 1'b1; r.st.dly = d4; r.st.phase = PH_P3; end
			PH_P3: begin r.st.pull = 1'b0; r.st.phase = PH_IDLE; r.st.dly = '0; r.done = 1'b1; end
			PH_W0: begin
				r.st.pull = 1'b1; r.st.scl = 1'b0; r.st.bcnt = '0;
				r.st.phase = PH_WB1; r.cont = 1'b1;
			end
			PH_WB1: begin
				r.st.pull  = ~s.shreg[7];
				r.st.scl   = 1'b0;
				r.st.shreg = {s.shreg[6:0], 1'b0};
				r.st.dly   = d2; r.st.phase = PH_WB2;
			end
			PH_WB2: begin r.st.scl = 1'b1; r.st.dly = d2; r.st.phase = PH_WB3; end
			PH_WB3: begin
				r.st.scl   = 1'b0;
				r.st.bcnt  = s.bcnt + 4'd1;
				r.st.phase = (r.st.bcnt < 4'd8) ? PH_WB1 : PH_WT1;
				r.cont     = 1'b1;
			end
			PH_WT1: begin r.st.scl = 1'b0; r.st.dly = d2; r.st.phase = PH_WT2; end
			PH_WT2: begin r.st.pull = 1'b1; r.st.dly = d2; r.st.phase = PH_WT3; end
			PH_WT3: begin r.st.phase = PH_IDLE; r.st.dly = '0; r.done = 1'b1; end
			PH_R0: begin
				r.st.pull = 1'b0; r.st.bcnt = '0; r.st.shreg = '0;
				r.st.dly = d2; r.st.phase = PH_RB1;
			end
			PH_RB1: begin r.st.scl = 1'b0; r.st.dly = d2; r.st.phase = PH_RB2; end
			PH_RB2: begin r.st.scl = 1'b1; r.st.dly = d2; r.st.phase = PH_RB3; end
			PH_RB3: begin
				r.st.shreg = {s.shreg[6:0], sda_in};
				r.st.dly = d2; r.st.phase = PH_RB4;
			end
			PH_RB4: begin r.st.scl = 1'b0; r.st.dly = d2; r.st.phase = PH_RB5; end
			PH_RB5: begin
				r.st.bcnt  = s.bcnt + 4'd1;
				r.st.phase = (r.st.bcnt < 4'd8) ? PH_RB1 : PH_RA1;
				r.cont     = 1'b1;
			end
			PH_RA1: begin
				r.st.scl = 1'b0; r.st.pull = ~s.nackl;
				r.st.dly = d2; r.st.phase = PH_RA2;
			end
			PH_RA2: begin r.st.scl = 1'b1; r.st.dly = d2; r.st.phase = PH_RA3; end
			PH_RA3: begin
				r.st.scl = 1'b0; r.st.rx = s.shreg;
				r.st.phase = PH_IDLE; r.st.dly = '0; r.done = 1'b1;
			end
			PH_A0: begin r.st.pull = 1'b0; r.st.dly = d2; r.st.phase = PH_A1; end
			PH_A1: begin r.st.pull = 1'b0; r.st.dly = d1; r.st.phase = PH_A2; end
			PH_A2: begin r.st.scl = 1'b1; r.st.dly = d1; r.st.phase = PH_A3; end
			PH_A3: begin
				if (!sda_in) begin
					r.st.scl = 1'b0; r.st.ackf = 1'b0;
					r.st.phase = PH_IDLE; r.st.dly = '0; r.done = 1'b1;
				end else if (s.poll >= limit) begin
					// timed out: fall straight into a stop
					r.st.ackf = 1'b1; r.st.phase = PH_P1; r.cont = 1'b1;
				end else begin
					r.st.poll = s.poll + 8'd1;
					r.st.dly  = '0;
				end
			end
			default: begin r.st.phase = PH_IDLE; r.st.dly = '0; end
		endcase
		return r;
	endfunction

	// entry: command decode, delay countdown
	always_comb begin
		s0  = cur;
		run = 1'b0;
		if (cur.phase == PH_IDLE) begin
			if (cmd_valid && func <= FN_WACK) begin
				run = 1'b1;
				case (func)
					FN_START: s0.phase = PH_S1;
					FN_STOP:  s0.phase = PH_P1;
					FN_WRITE: begin s0.phase = PH_W0; s0.shreg = tx_byte; end
					FN_READ:  begin s0.phase = PH_R0; s0.nackl = nack_after_read; end
					default:  begin s0.phase = PH_A0; s0.poll = '0; s0.ackf = 1'b0; end
				endcase
			end
		end else if (cur.dly != '0) begin
			s0.dly = cur.dly - DLY_W'(1);
			run    = (s0.dly == '0);
		end else begin
			run = 1'b1;
		end
	end

	// at most two chained actions per tick
	always_comb begin
		a1 = run ? act(s0) : act_t'{st: s0, cont: 1'b0, done: 1'b0};
		a2 = a1.cont ? act(a1.st) : a1;
		nxt  = a2.st;
		done = a1.done | a2.done;
	end

endmodule
